// File: hw/rtl/dss_pkg.sv
// dss_pkg: shared types and constants of the delimiter stream splitter
// used by dss_front, dss_queue, dss_back and the top level
// no dependencies
`timescale 1ns / 1ps

package dss_pkg;

  // longest separator in bytes and the most bytes held back between words
  localparam int unsigned SepMax  = 8;
  localparam int unsigned HeldMax = SepMax - 1;
  localparam int unsigned CntW    = 3;   // holds 0..HeldMax
  localparam int unsigned WinW    = 4;   // holds 0..SepMax

  // configuration register indexes
  typedef enum logic [0:0] {
    RegSepBytes  = 1'b0,
    RegSepLength = 1'b1
  } cfg_reg_e;

  // one classified input word: window bytes and which positions give a result
  typedef struct packed {
    logic [SepMax-1:0][7:0] win;
    logic [SepMax-1:0]      byte_mask;
    logic [SepMax-1:0]      end_mask;
    logic                   done;
  } entry_t;

endpackage

// File: hw/rtl/delimiter_stream_splitter_unit.sv
// delimiter_stream_splitter_unit: top level of the separator stream splitter
// depends on dss_pkg, dss_front, dss_queue, dss_back
//
// Usage
//   Input words (command_i, data_byte_i) go in on push when full is low.
//   A data byte is scanned with the held-back bytes against the separator;
//   an end-of-array word flushes the held bytes and closes the array.
//   Result words leave through empty and pop, one per accepted pop, each
//   a payload byte or a block end; last_o marks the final word of an input.
//   Configuration writes go through cfg_valid_i/cfg_ready_o (always ready):
//   index 0 is the separator bytes, index 1 the separator length.
//   Write them only while the unit is idle.
// Timing
//   One input word per cycle while full is low; the separator scan finishes
//   in the cycle of acceptance. A word's entry is written into the queue and
//   then loaded into the result register of the back end, which puts its
//   first result on the ports. Results leave at one per cycle while pop is
//   high; inputs keep entering until the entry queue fills.
// Reset and stall
//   Reset empties the queue and the held window and restores length 1.
//   While pop stays low the result word holds and full rises once the
//   entry queue is full.
`timescale 1ns / 1ps

module delimiter_stream_splitter_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        block_end_o,
  output logic        array_done_o,
  output logic        last_o
);

  dss_pkg::entry_t enq_entry, head_entry;
  logic            enq, q_rd, q_empty, q_full, accept;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  // front: classify each accepted word
  dss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .enq_o       (enq),
    .entry_o     (enq_entry)
  );

  // queue between front and back
  dss_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (enq),
    .wr_data_i (enq_entry),
    .rd_i      (q_rd),
    .rd_data_o (head_entry),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  // back: emit result words
  dss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (head_entry),
    .q_empty_i    (q_empty),
    .q_rd_o       (q_rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .block_end_o  (block_end_o),
    .array_done_o (array_done_o),
    .last_o       (last_o)
  );

endmodule

// File: hw/rtl/dss_front.sv
// dss_front: configuration registers, held-back window and separator scan
// classifies each input word into an entry of result positions
// depends on dss_pkg
`timescale 1ns / 1ps

module dss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                accept_i,
  input  logic                command_i,
  input  logic [7:0]          data_byte_i,
  output logic                enq_o,
  output dss_pkg::entry_t     entry_o
);

  logic [63:0]                        sep_bytes_q;
  logic [3:0]                         sep_len_q;
  logic [dss_pkg::HeldMax-1:0][7:0]   held_q, held_d;
  logic [dss_pkg::CntW-1:0]           held_cnt_q, held_cnt_d;

  logic [dss_pkg::WinW-1:0]           len;
  logic [dss_pkg::WinW-1:0]           w;
  logic [dss_pkg::WinW-1:0]           s;
  logic [dss_pkg::SepMax-1:0][7:0]    buf_w;
  logic [dss_pkg::SepMax-1:0][7:0]    sep;
  logic [dss_pkg::SepMax-1:0]         pre, full, stop;
  logic [dss_pkg::SepMax:0]           reached;
  logic [dss_pkg::SepMax-1:0]         data_byte_mask, data_end_mask;
  logic [dss_pkg::SepMax-1:0]         eoa_byte_mask, eoa_end_mask;
  dss_pkg::entry_t                    entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_bytes_q <= '0;
      sep_len_q   <= 4'd1;
    end else if (cfg_valid_i) begin
      unique case (dss_pkg::cfg_reg_e'(cfg_index_i))
        dss_pkg::RegSepBytes:  sep_bytes_q <= cfg_data_i;
        dss_pkg::RegSepLength: sep_len_q   <= cfg_data_i[3:0];
        default:               sep_bytes_q <= sep_bytes_q;
      endcase
    end
  end

  // effective separator length, zero acts as one, clamp at the maximum
  always_comb begin
    if (sep_len_q == 4'd0) begin
      len = 4'd1;
    end else if (sep_len_q > 4'(dss_pkg::SepMax)) begin
      len = 4'(dss_pkg::SepMax);
    end else begin
      len = sep_len_q;
    end
  end

  assign sep = sep_bytes_q;

  // window of held bytes followed by the new byte
  always_comb begin
    for (int p = 0; p < dss_pkg::SepMax; p++) begin
      if (p < dss_pkg::HeldMax && 3'(p) != held_cnt_q) begin
        buf_w[p] = held_q[p];
      end else begin
        buf_w[p] = data_byte_i;
      end
    end
  end

  assign w = 4'(held_cnt_q) + 4'd1;

  // separator compare at every window position
  always_comb begin
    for (int p = 0; p < dss_pkg::SepMax; p++) begin
      pre[p] = 1'b1;
      for (int k = 0; k < dss_pkg::SepMax; k++) begin
        if (p + k < dss_pkg::SepMax) begin
          if (k < int'(len) && p + k < int'(w) && buf_w[p+k] != sep[k]) begin
            pre[p] = 1'b0;
          end
        end
      end
      full[p] = pre[p] && (p + int'(len) <= int'(w));
      stop[p] = pre[p] && !full[p] && (p < int'(w));
    end
  end

  // walk of the scan: which positions the leftmost match reaches
  always_comb begin
    reached    = '0;
    reached[0] = 1'b1;
    for (int q = 1; q <= dss_pkg::SepMax; q++) begin
      reached[q] = reached[q-1] && !pre[q-1] && (q - 1 < int'(w));
      for (int k = 1; k <= dss_pkg::SepMax; k++) begin
        if (k <= q && k == int'(len) && reached[q-k] && full[q-k]) begin
          reached[q] = 1'b1;
        end
      end
    end
  end

  // stop position, where the rest could still begin a separator
  always_comb begin
    s = w;
    for (int p = dss_pkg::SepMax - 1; p >= 0; p--) begin
      if (reached[p] && stop[p]) begin
        s = 4'(p);
      end
    end
  end

  // result positions for both kinds of word
  always_comb begin
    for (int p = 0; p < dss_pkg::SepMax; p++) begin
      data_byte_mask[p] = reached[p] && !pre[p] && (p < int'(w));
      data_end_mask[p]  = reached[p] && full[p];
      eoa_byte_mask[p]  = (p < int'(held_cnt_q));
      eoa_end_mask[p]   = (p == int'(held_cnt_q));
    end
  end

  // next held window
  always_comb begin
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    if (command_i) begin
      held_cnt_d = '0;
    end else begin
      for (int i = 0; i < dss_pkg::HeldMax; i++) begin
        held_d[i] = buf_w[3'(int'(s) + i)];
      end
      held_cnt_d = 3'(w - s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= '0;
    end else if (accept_i) begin
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

  // entry handed to the queue
  always_comb begin
    entry.win       = buf_w;
    entry.byte_mask = command_i ? eoa_byte_mask : data_byte_mask;
    entry.end_mask  = command_i ? eoa_end_mask  : data_end_mask;
    entry.done      = command_i;
  end

  assign entry_o = entry;
  assign enq_o   = accept_i && ((entry.byte_mask | entry.end_mask) != '0);

  // checks
  held_cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= 3'(dss_pkg::HeldMax))
    else $error("held count beyond window");

  eoa_clears_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && command_i |=> held_cnt_q == '0)
    else $error("end of array left bytes held");

  eoa_enqueues_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && command_i |-> enq_o)
    else $error("end of array gave no entry");

endmodule

// File: hw/rtl/dss_queue.sv
// dss_queue: short queue of classified entries between front and back
// depends on dss_pkg
`timescale 1ns / 1ps

module dss_queue #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  dss_pkg::entry_t wr_data_i,
  input  logic            rd_i,
  output dss_pkg::entry_t rd_data_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  dss_pkg::entry_t     mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign empty_o   = (cnt_q == '0);
  assign full_o    = (cnt_q == CntW'(QUEUE_DEPTH));
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers with wrap at the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // checks
  no_lost_write_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("entry written into a full queue");

  no_empty_read_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("entry read from an empty queue");

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: hw/rtl/dss_back.sv
// dss_back: unpacks one entry into result words, one per cycle while pop is high
// depends on dss_pkg
`timescale 1ns / 1ps

module dss_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dss_pkg::entry_t q_data_i,
  input  logic            q_empty_i,
  output logic            q_rd_o,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            block_end_o,
  output logic            array_done_o,
  output logic            last_o
);

  dss_pkg::entry_t            cur_q, cur_d;
  logic [dss_pkg::SepMax-1:0] rem_q, rem_d;
  logic                       cur_valid_q, cur_valid_d;
  logic [dss_pkg::SepMax-1:0] low_bit, rest;
  logic [2:0]                 idx;
  logic                       taken, load;

  // lowest pending position
  assign low_bit = rem_q & (~rem_q + 1'b1);
  assign rest    = rem_q & ~low_bit;

  always_comb begin
    idx = '0;
    for (int p = dss_pkg::SepMax - 1; p >= 0; p--) begin
      if (rem_q[p]) begin
        idx = 3'(p);
      end
    end
  end

  // result word on the ports
  assign empty        = !cur_valid_q;
  assign byte_valid_o = cur_q.byte_mask[idx];
  assign block_end_o  = cur_q.end_mask[idx];
  assign array_done_o = cur_q.done && cur_q.end_mask[idx];
  assign out_byte_o   = cur_q.byte_mask[idx] ? cur_q.win[idx] : 8'h00;
  assign last_o       = (rest == '0);

  // advance: next position, or next entry from the queue
  assign taken  = pop && cur_valid_q;
  assign load   = (!cur_valid_q || (taken && last_o)) && !q_empty_i;
  assign q_rd_o = load;

  always_comb begin
    cur_d       = cur_q;
    rem_d       = rem_q;
    cur_valid_d = cur_valid_q;
    if (load) begin
      cur_d       = q_data_i;
      rem_d       = q_data_i.byte_mask | q_data_i.end_mask;
      cur_valid_d = 1'b1;
    end else if (taken) begin
      rem_d       = rest;
      cur_valid_d = !last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // checks
  pending_nonzero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> rem_q != '0)
    else $error("valid entry with nothing pending");

  one_kind_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> byte_valid_o != block_end_o)
    else $error("result word is both byte and block end");

  done_is_last_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && array_done_o |-> last_o)
    else $error("array end not the last word of its input");

endmodule
